// ===== hdl/tfd_pkg.sv =====
package tfd_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int TEX_WORD_W = 16;
  localparam int TEX_IDX_W  = 22;
  localparam int TEX_DEPTH  = 4194304;

  localparam int COORD_W   = 32;
  localparam int TEXEL_W   = 10;
  localparam int SIZE_W    = 11;
  localparam int OFFSET_W  = 22;
  localparam int BASE_W    = 21;
  localparam int STRIDE_W  = 5;
  localparam int CODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = BASE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXTURE_BASE  = 3'd0,
    REG_LINEAR_LAYOUT = 3'd1,
    REG_USE_STRIDE    = 3'd2,
    REG_STRIDE_UNITS  = 3'd3,
    REG_PIXEL_FORMAT  = 3'd4,
    REG_WIDTH_CODE    = 3'd5,
    REG_HEIGHT_CODE   = 3'd6
  } cfg_reg_t;

  localparam logic [2:0] FMT_1555     = 3'd0;
  localparam logic [2:0] FMT_565      = 3'd1;
  localparam logic [2:0] FMT_4444     = 3'd2;
  localparam logic [2:0] FMT_1555_ALT = 3'd7;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NONSQUARE = 2'd1;
  localparam logic [1:0] STATUS_FORMAT    = 2'd2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_ADDR,
    ST_DATA
  } fetch_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctrl_t;

endpackage

// ===== hdl/tfd_ram.sv =====
module tfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/tfd_texel.sv =====
module tfd_texel
  import tfd_pkg::*;
#(
  parameter int FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic [COORD_W-1:0] coord,
  input  logic [CODE_W-1:0]  size_code,
  output logic [TEXEL_W-1:0] texel
);

  logic [FRAC_BITS+TEXEL_W-1:0] scaled;
  logic [SIZE_W-1:0]            size;
  logic [TEXEL_W-1:0]           texel_max;

  // size = 8 << code; the product coord*size is a plain left shift
  assign size      = SIZE_W'(8) << size_code;
  assign texel_max = TEXEL_W'(size - SIZE_W'(1));
  assign scaled    = {{TEXEL_W{1'b0}}, coord[FRAC_BITS-1:0]} <<
                     ((CODE_W+1)'(size_code) + (CODE_W+1)'(3));

  always_comb begin
    if (coord[COORD_W-1]) begin
      texel = '0;
    end else if (|coord[COORD_W-2:FRAC_BITS]) begin
      texel = texel_max;
    end else begin
      texel = scaled[FRAC_BITS+TEXEL_W-1:FRAC_BITS];
    end
  end

endmodule

// ===== hdl/twiddled_texture_fetch_decode_core.sv =====
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   req_type u_coord v_coord write_index write_data
// response  out        rsp_valid/rsp_stall   red green blue alpha word_read status
// config    in         cfg_write             cfg_index cfg_data
//
// Each request goes through accept, texel/offset calc, address and memory access,
// decode. The single memory port and one-item sequencer take no new request until
// the last is through. The response register parts the two sides: the next request
// is taken while a result still waits on rsp_stall. Reset clears control and config;
// the texture memory is undefined until written. A stalled response holds its payload.
module twiddled_texture_fetch_decode_core
  import tfd_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   req_type,
  input  logic signed [COORD_W-1:0] u_coord,
  input  logic signed [COORD_W-1:0] v_coord,
  input  logic [TEX_IDX_W-1:0]   write_index,
  input  logic [TEX_WORD_W-1:0]  write_data,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  output logic [7:0]             alpha,
  output logic [TEX_IDX_W-1:0]   word_read,
  output logic [1:0]             status,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [BASE_W-1:0]   texture_base;
  logic                linear_layout;
  logic                use_stride;
  logic [STRIDE_W-1:0] stride_units;
  logic [2:0]          pixel_format;
  logic [CODE_W-1:0]   width_code;
  logic [CODE_W-1:0]   height_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_base  <= '0;
      linear_layout <= 1'b0;
      use_stride    <= 1'b0;
      stride_units  <= '0;
      pixel_format  <= '0;
      width_code    <= '0;
      height_code   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEXTURE_BASE:  texture_base  <= cfg_data[BASE_W-1:0];
        REG_LINEAR_LAYOUT: linear_layout <= cfg_data[0];
        REG_USE_STRIDE:    use_stride    <= cfg_data[0];
        REG_STRIDE_UNITS:  stride_units  <= cfg_data[STRIDE_W-1:0];
        REG_PIXEL_FORMAT:  pixel_format  <= cfg_data[2:0];
        REG_WIDTH_CODE:    width_code    <= cfg_data[CODE_W-1:0];
        REG_HEIGHT_CODE:   height_code   <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  fetch_state_t state;
  fetch_state_t state_next;
  ram_ctrl_t    ram_ctrl;
  logic         req_xfer;
  logic         rsp_load;

  assign req_stall = (state != ST_IDLE);
  assign req_xfer  = req_valid && !req_stall;

  // Captured request
  logic                  req_type_q;
  logic [COORD_W-1:0]    u_q;
  logic [COORD_W-1:0]    v_q;
  logic [TEX_IDX_W-1:0]  write_index_q;
  logic [TEX_WORD_W-1:0] write_data_q;

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_type_q    <= req_type;
      u_q           <= u_coord;
      v_q           <= v_coord;
      write_index_q <= write_index;
      write_data_q  <= write_data;
    end
  end

  // Calc stage: texel coordinates, texel offset, status
  logic [TEXEL_W-1:0]  tex_u;
  logic [TEXEL_W-1:0]  tex_v;
  logic [SIZE_W-1:0]   tex_width;
  logic [SIZE_W-1:0]   row_len;
  logic [OFFSET_W-1:0] morton_off;
  logic [OFFSET_W-1:0] linear_off;
  logic [OFFSET_W-1:0] offset_next;
  logic [1:0]          status_next;
  logic [OFFSET_W-1:0] offset;
  logic [1:0]          item_status;

  tfd_texel #(.FRAC_BITS(COORD_FRAC_BITS)) u_texel_u (
    .coord     (u_q),
    .size_code (width_code),
    .texel     (tex_u)
  );

  tfd_texel #(.FRAC_BITS(COORD_FRAC_BITS)) u_texel_v (
    .coord     (v_q),
    .size_code (height_code),
    .texel     (tex_v)
  );

  assign tex_width  = SIZE_W'(8) << width_code;
  assign row_len    = use_stride ? SIZE_W'({stride_units, 5'b0}) : tex_width;
  assign linear_off = OFFSET_W'(tex_v) * OFFSET_W'(row_len) + OFFSET_W'(tex_u);

  // Interleave: v in the even bits, u in the odd bits
  always_comb begin
    morton_off = '0;
    for (int k = 0; k < TEXEL_W; k++) begin
      morton_off[2*k]   = tex_v[k];
      morton_off[2*k+1] = tex_u[k];
    end
  end

  assign offset_next = linear_layout ? linear_off : morton_off;

  always_comb begin
    priority if (req_type_q == REQ_WRITE) begin
      status_next = STATUS_OK;
    end else if (!linear_layout && (width_code != height_code)) begin
      status_next = STATUS_NONSQUARE;
    end else if (pixel_format == FMT_1555 || pixel_format == FMT_1555_ALT ||
                 pixel_format == FMT_565 || pixel_format == FMT_4444) begin
      status_next = STATUS_OK;
    end else begin
      status_next = STATUS_FORMAT;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      offset      <= offset_next;
      item_status <= status_next;
    end
  end

  // Address stage: base add and bank swizzle
  logic [24:0]          byte_addr;
  logic [TEX_IDX_W-1:0] widx;
  logic [TEX_IDX_W-1:0] widx_q;
  logic [TEX_IDX_W-1:0] ram_addr;
  logic                 no_read;

  assign byte_addr = {1'b0, texture_base, 3'b0} + {2'b0, offset, 1'b0};
  assign widx      = {byte_addr[23] | byte_addr[2], byte_addr[22:3], byte_addr[1]};
  assign no_read   = (req_type_q == REQ_WRITE) || (item_status == STATUS_NONSQUARE);
  assign ram_addr  = (req_type_q == REQ_WRITE) ? write_index_q : widx;

  always_ff @(posedge clk) begin
    if (state == ST_ADDR) begin
      widx_q <= no_read ? '0 : widx;
    end
  end

  logic [TEX_WORD_W-1:0] texel_word;

  tfd_ram #(.WIDTH(TEX_WORD_W), .DEPTH(TEX_DEPTH)) u_tex_mem (
    .clk   (clk),
    .rd_en (ram_ctrl.rd_en),
    .wr_en (ram_ctrl.wr_en),
    .addr  (ram_addr),
    .wdata (write_data_q),
    .rdata (texel_word)
  );

  always_comb begin
    state_next     = state;
    ram_ctrl.rd_en = 1'b0;
    ram_ctrl.wr_en = 1'b0;
    rsp_load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        ram_ctrl.wr_en = (req_type_q == REQ_WRITE);
        ram_ctrl.rd_en = !no_read;
        state_next     = ST_DATA;
      end
      ST_DATA: begin
        // hold the read word until the response register frees up
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode stage
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;
  logic [7:0] alpha_next;

  always_comb begin
    red_next   = '0;
    green_next = '0;
    blue_next  = '0;
    alpha_next = '0;
    if ((req_type_q == REQ_SAMPLE) && (item_status == STATUS_OK)) begin
      unique case (pixel_format)
        FMT_565: begin
          red_next   = {texel_word[15:11], 3'b0};
          green_next = {texel_word[10:5], 2'b0};
          blue_next  = {texel_word[4:0], 3'b0};
          alpha_next = 8'hff;
        end
        FMT_4444: begin
          red_next   = {texel_word[11:8], 4'b0};
          green_next = {texel_word[7:4], 4'b0};
          blue_next  = {texel_word[3:0], 4'b0};
          alpha_next = {texel_word[15:12], 4'b0};
        end
        default: begin
          red_next   = {texel_word[14:10], 3'b0};
          green_next = {texel_word[9:5], 3'b0};
          blue_next  = {texel_word[4:0], 3'b0};
          alpha_next = {8{texel_word[15]}};
        end
      endcase
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      red       <= red_next;
      green     <= green_next;
      blue      <= blue_next;
      alpha     <= alpha_next;
      word_read <= widx_q;
      status    <= item_status;
    end
  end

endmodule
